// ----- src/rmd_pkg.sv -----
package rmd_pkg;

  localparam int PAGE_BITS          = 12;
  localparam int ADDR_W             = 32;
  localparam int PAGE_ADDR_W        = ADDR_W - PAGE_BITS;  // 20
  localparam int PAGE_CNT_W         = PAGE_ADDR_W + 1;     // up to 2^20 pages
  localparam int FIELD_W            = 24;
  localparam int KIND_W             = 3;
  localparam int IDX_W              = 3;
  localparam int STATUS_W           = 2;
  localparam int CFG_W              = 4;
  localparam int RESULT_CAP         = 8;
  localparam int MAX_RANGE_REGS_DEF = 8;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request, prepare run
    logic step;   // emit one entry into the output register
  } rmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a word this cycle
    logic final_entry; // entry being formed ends the run
  } rmd_sts_t;

endpackage

// ----- src/rmd_req_if.sv -----
interface rmd_req_if;
  logic                       valid;
  logic                       ready;
  logic [rmd_pkg::ADDR_W-1:0] base_address;
  logic [rmd_pkg::ADDR_W-1:0] range_bytes;
  logic [rmd_pkg::KIND_W-1:0] memory_kind;

  modport source (output valid, base_address, range_bytes, memory_kind, input ready);
  modport sink   (input valid, base_address, range_bytes, memory_kind, output ready);
endinterface

// ----- src/rmd_entry_if.sv -----
interface rmd_entry_if;
  logic                         valid;
  logic                         ready;
  logic [rmd_pkg::IDX_W-1:0]    entry_index;
  logic [rmd_pkg::FIELD_W-1:0]  base_page;
  logic [rmd_pkg::FIELD_W-1:0]  page_mask;
  logic [rmd_pkg::KIND_W-1:0]   entry_kind;
  logic [rmd_pkg::STATUS_W-1:0] status;
  logic                         last_entry;

  modport source (output valid, entry_index, base_page, page_mask, entry_kind, status,
                  last_entry, input ready);
  modport sink   (input valid, entry_index, base_page, page_mask, entry_kind, status,
                  last_entry, output ready);
endinterface

// ----- src/rmd_cfg_if.sv -----
interface rmd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rmd_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/range_to_mtrr_decomposer_core.sv -----
// Range to variable-range entry splitter.
//
// req   : one word per range: byte base, byte length, memory type.
// entry : one word per variable-range entry: index, base page, page mask,
//         type, status (ok / hit register limit / empty range) and a last
//         flag on the final word of the range.
// cfg   : writes the number of variable range registers (ready is always
//         high; write only while no range is in flight).
//
// Flow: the request is taken in the idle state, then each step in the run
// state writes one entry into the output register, one entry per cycle
// while that register is free. The single entry generator forms one entry
// per step, and a range of up to eight entries holds the block until done.
// A new request is taken as soon as the last entry is in the output
// register, even if the sink has not taken it yet.
// If the sink stalls, the generator holds and resumes when the output
// register frees up; nothing is dropped.
// Reset: controller idle, output empty, register count back to 8.
module range_to_mtrr_decomposer_core #(
  parameter int MAX_RANGE_REGS = rmd_pkg::MAX_RANGE_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rmd_req_if.sink     req,
  rmd_entry_if.source entry,
  rmd_cfg_if.sink     cfg
);

  // command/status between sequencer and datapath
  rmd_pkg::rmd_cmd_t cmd;
  rmd_pkg::rmd_sts_t sts;

  // sequencer: idle / run, one entry per step when the output frees
  rmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: page rounding, alignment chunk, leading-bit split,
  // config register and output register
  rmd_dp #(
    .MAX_RANGE_REGS (MAX_RANGE_REGS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .entry (entry),
    .cfg   (cfg),
    .cmd   (cmd),
    .sts   (sts)
  );

endmodule

// ----- src/rmd_ctrl.sv -----
module rmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output rmd_pkg::rmd_cmd_t cmd,
  input  rmd_pkg::rmd_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.final_entry) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/rmd_dp.sv -----
module rmd_dp #(
  parameter int MAX_RANGE_REGS = rmd_pkg::MAX_RANGE_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  rmd_req_if.sink           req,
  rmd_entry_if.source       entry,
  rmd_cfg_if.sink           cfg,
  input  rmd_pkg::rmd_cmd_t cmd,
  output rmd_pkg::rmd_sts_t sts
);

  localparam int CW  = rmd_pkg::PAGE_CNT_W;
  localparam int PW  = rmd_pkg::PAGE_ADDR_W;
  localparam int AW  = rmd_pkg::ADDR_W;
  localparam int PB  = rmd_pkg::PAGE_BITS;
  localparam int FW  = rmd_pkg::FIELD_W;
  localparam int IW  = rmd_pkg::IDX_W;
  localparam int LIM_CAP = (MAX_RANGE_REGS < rmd_pkg::RESULT_CAP) ?
                           MAX_RANGE_REGS : rmd_pkg::RESULT_CAP;
  localparam logic [rmd_pkg::CFG_W-1:0] CAP_V = rmd_pkg::CFG_W'(LIM_CAP);

  // highest set bit of a page count (0 stays 0)
  function automatic logic [CW-1:0] top_bit(input logic [CW-1:0] v);
    logic [CW-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s ^ (s >> 1);
  endfunction

  // config register
  logic [rmd_pkg::CFG_W-1:0] reg_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= rmd_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      reg_count <= cfg.data;
    end
  end

  // run registers
  logic [CW-1:0]              pages;
  logic [CW-1:0]              chunk;
  logic                       aligned;
  logic [PW-1:0]              page_base;
  logic [IW-1:0]              idx;
  logic [IW-1:0]              last_idx;
  logic [rmd_pkg::KIND_W-1:0] kind;
  logic                       empty;

  // load-time values
  logic [CW-1:0]             pages_in;
  logic [AW-1:0]             low_bit;
  logic [CW-1:0]             chunk_in;
  logic [rmd_pkg::CFG_W-1:0] eff_count;

  always_comb begin
    pages_in = CW'(req.range_bytes[AW-1:PB]) + CW'(req.range_bytes[PB-1:0] != '0);
    low_bit  = req.base_address & (~req.base_address + AW'(1));
    if (req.base_address == '0) begin
      chunk_in = CW'(1) << PW;                // zero base: 4 GiB aligned
    end else if (req.base_address[PB-1:0] != '0) begin
      chunk_in = CW'(1);
    end else begin
      chunk_in = CW'(low_bit[AW-1:PB]);
    end
    if (reg_count == '0) begin
      eff_count = rmd_pkg::CFG_W'(1);
    end else if (reg_count > CAP_V) begin
      eff_count = CAP_V;
    end else begin
      eff_count = reg_count;
    end
  end

  // step-time values
  logic          use_chunk;
  logic [CW-1:0] size;
  logic [CW-1:0] pages_left;
  logic          at_limit;
  logic          fin;

  always_comb begin
    use_chunk  = aligned && (pages >= chunk);
    size       = use_chunk ? chunk : top_bit(pages);
    pages_left = pages - size;
    at_limit   = (idx == last_idx);
    fin        = empty || (pages_left == '0) || at_limit;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pages     <= pages_in;
      chunk     <= chunk_in;
      aligned   <= 1'b1;
      page_base <= req.base_address[AW-1:PB];
      idx       <= '0;
      last_idx  <= IW'(eff_count - rmd_pkg::CFG_W'(1));
      kind      <= req.memory_kind;
      empty     <= (pages_in == '0);
    end else if (cmd.step) begin
      pages     <= pages_left;
      aligned   <= use_chunk;
      page_base <= page_base + size[PW-1:0];
      idx       <= idx + IW'(1);
    end
  end

  // output register
  logic out_valid;

  assign sts.out_free    = !out_valid || entry.ready;
  assign sts.final_entry = fin;
  assign entry.valid     = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (entry.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      entry.entry_kind <= kind;
      entry.last_entry <= fin;
      if (empty) begin
        entry.entry_index <= '0;
        entry.base_page   <= '0;
        entry.page_mask   <= '0;
        entry.status      <= rmd_pkg::ST_EMPTY;
      end else begin
        entry.entry_index <= idx;
        entry.base_page   <= FW'(page_base);
        entry.page_mask   <= ~(FW'(size) - FW'(1));
        entry.status      <= at_limit ? rmd_pkg::ST_LIMIT : rmd_pkg::ST_OK;
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rmd_pkg::*;

  // The dut keeps its default register ceiling.
  localparam int MAX_REGS         = MAX_RANGE_REGS_DEF;
  localparam int DIR_ROWS         = 18;
  localparam int RANDOM_PER_PHASE = 49;
  localparam int N_PHASES         = 8;
  localparam int IDLE_PCT         = 32;
  localparam int CALM_PHASE       = 4;

  // One variable-range entry word as the sink sees it.
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [FIELD_W-1:0]  base_page;
    logic [FIELD_W-1:0]  page_mask;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic                last;
  } entry_t;

  // Directed row: request, plus a hand-written entry where the answer is a
  // single obvious word (typed = 1). Other rows go through the predictor.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] bytes;
    logic [KIND_W-1:0] kind;
    logic              typed;
    entry_t            want;
  } dir_row_t;

  localparam entry_t NO_WANT = '0;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty range, both base extremes
    '{32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1,
      '{3'd0, 24'h000000, 24'h000000, 3'd0, ST_EMPTY, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 1'b1,
      '{3'd0, 24'h000000, 24'h000000, 3'd7, ST_EMPTY, 1'b1}},
    // zero base counts as 4 GiB aligned: whole space in one entry
    '{32'h0000_0000, 32'hFFFF_FFFF, 3'd7, 1'b1,
      '{3'd0, 24'h000000, 24'hF00000, 3'd7, ST_OK, 1'b1}},
    // one byte rounds up to one page
    '{32'h0000_0000, 32'h0000_0001, 3'd1, 1'b1,
      '{3'd0, 24'h000000, 24'hFFFFFF, 3'd1, ST_OK, 1'b1}},
    // top half of the space, one aligned entry
    '{32'h8000_0000, 32'h8000_0000, 3'd2, 1'b1,
      '{3'd0, 24'h080000, 24'hF80000, 3'd2, ST_OK, 1'b1}},
    // smallest byte count that still gives 2^20 pages
    '{32'h0000_0000, 32'hFFFF_F001, 3'd5, 1'b1,
      '{3'd0, 24'h000000, 24'hF00000, 3'd5, ST_OK, 1'b1}},
    '{32'hFFFF_F000, 32'h0000_3000, 3'd3, 1'b0, NO_WANT}, // base wraps past 4 GiB
    '{32'h0000_1000, 32'h0000_8000, 3'd4, 1'b0, NO_WANT}, // limit hit on exact cover
    '{32'h0000_1000, 32'h0000_8001, 3'd4, 1'b0, NO_WANT}, // limit hit, range left over
    '{32'h0010_0000, 32'h0035_0000, 3'd6, 1'b0, NO_WANT}, // aligned run then falling
    '{32'h0000_0123, 32'h0000_1001, 3'd0, 1'b0, NO_WANT}, // unaligned base, low bits kept
    '{32'h0000_0000, 32'hFFFF_F000, 3'd1, 1'b0, NO_WANT}, // 20 set bits, runs out
    '{32'h4000_0000, 32'hFFFF_FFFF, 3'd2, 1'b0, NO_WANT}, // four 1 GiB, last wraps
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd6, 1'b0, NO_WANT}, // all ones
    '{32'h0040_0000, 32'h0000_1000, 3'd0, 1'b0, NO_WANT}, // range below alignment
    '{32'h1234_5000, 32'h0000_7000, 3'd3, 1'b0, NO_WANT},
    '{32'h0001_0000, 32'h0000_F800, 3'd5, 1'b0, NO_WANT}, // rounds to exactly 16 pages
    '{32'hABCD_E000, 32'h0000_0FFF, 3'd7, 1'b0, NO_WANT}
  };

  // Register settings per random phase: one, zero, all ones, the ceiling, middles.
  localparam logic [CFG_W-1:0] PHASE_COUNTS [N_PHASES] = '{
    4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd12, 4'd7
  };

  logic clk;
  logic rst;

  rmd_req_if   req_bus ();
  rmd_entry_if ent_bus ();
  rmd_cfg_if   cfg_bus ();

  range_to_mtrr_decomposer_core dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_bus),
    .entry (ent_bus),
    .cfg   (cfg_bus)
  );

  entry_t           pending_entries [$];  // entry words still owed by the dut
  logic [CFG_W-1:0] range_count;          // our copy of the register
  int               mismatches;
  bit               calm;                 // no idling on either side

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Split one request into the entry words the block should emit.
  function automatic void predict_entries(input logic [ADDR_W-1:0] base_in,
                                          input logic [ADDR_W-1:0] bytes_in,
                                          input logic [KIND_W-1:0] kind_in);
    logic [ADDR_W:0]       rounded;
    logic [PAGE_CNT_W-1:0] pages;
    logic [ADDR_W-1:0]     base;
    logic [31:0]           chunk;
    logic [31:0]           size;
    int                    tz;
    int                    lim;
    int                    n;
    entry_t                e;

    lim = int'(range_count);
    if (lim == 0) lim = 1;
    if (lim > MAX_REGS) lim = MAX_REGS;
    if (lim > RESULT_CAP) lim = RESULT_CAP;

    rounded = {1'b0, bytes_in} + 33'h0FFF;
    pages   = rounded[ADDR_W:PAGE_BITS];
    if (pages == '0) begin
      e        = '0;
      e.kind   = kind_in;
      e.status = ST_EMPTY;
      e.last   = 1'b1;
      pending_entries.push_back(e);
      return;
    end

    // natural alignment of the base; zero counts as 4 GiB aligned
    base = base_in;
    tz   = 0;
    if (base == '0) tz = ADDR_W;
    else while (!base[tz]) tz++;
    chunk = (tz > PAGE_BITS) ? (32'd1 << (tz - PAGE_BITS)) : 32'd1;

    n = 0;
    while (pages != '0) begin
      if ({11'd0, pages} >= chunk) begin
        size = chunk;
      end else begin
        // past the aligned run: highest set bit of what is left
        size = 32'd1;
        while (size <= ({11'd0, pages} >> 1)) size = size << 1;
        chunk = '1;
      end
      e.idx       = n[IDX_W-1:0];
      e.base_page = {4'd0, base[ADDR_W-1:PAGE_BITS]};
      e.page_mask = ~(size[FIELD_W-1:0] - 24'd1);
      e.kind      = kind_in;
      e.status    = ST_OK;
      e.last      = 1'b0;
      base  = base + (size << PAGE_BITS);  // wraps at 4 GiB
      pages = pages - size[PAGE_CNT_W-1:0];
      n++;
      if (n == lim) begin
        e.status = ST_LIMIT;
        e.last   = 1'b1;
      end else if (pages == '0) begin
        e.last = 1'b1;
      end
      pending_entries.push_back(e);
      if (n == lim) break;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sink side: random backpressure, none during the calm phase.
  always @(posedge clk) begin
    ent_bus.ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Entry monitor: every accepted word against the oldest expectation.
  always @(posedge clk) begin : watch_entries
    entry_t got;
    entry_t want;
    if (!rst && ent_bus.valid && ent_bus.ready) begin
      got.idx       = ent_bus.entry_index;
      got.base_page = ent_bus.base_page;
      got.page_mask = ent_bus.page_mask;
      got.kind      = ent_bus.entry_kind;
      got.status    = ent_bus.status;
      got.last      = ent_bus.last_entry;
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected entry word: expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = pending_entries.pop_front();
        check_field("entry_index", 32'(want.idx), 32'(got.idx));
        check_field("base_page", 32'(want.base_page), 32'(got.base_page));
        check_field("page_mask", 32'(want.page_mask), 32'(got.page_mask));
        check_field("entry_kind", 32'(want.kind), 32'(got.kind));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("last_entry", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Called right after a rising edge. Leaves valid high on return, so the
  // next call either keeps it high with new data or drops it for a gap.
  task automatic send_range(input logic [ADDR_W-1:0] base,
                            input logic [ADDR_W-1:0] bytes,
                            input logic [KIND_W-1:0] kind,
                            input logic typed, input entry_t want);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_bus.valid        <= 1'b1;
    req_bus.base_address <= base;
    req_bus.range_bytes  <= bytes;
    req_bus.memory_kind  <= kind;
    do @(posedge clk); while (!req_bus.ready);
    // word taken at this edge
    if (typed) pending_entries.push_back(want);
    else predict_entries(base, bytes, kind);
  endtask

  // Random request. Most bases carry a real alignment and most lengths are
  // sized around it, so the aligned run and the falling tail both show up.
  task automatic pick_range(output logic [ADDR_W-1:0] base,
                            output logic [ADDR_W-1:0] bytes,
                            output logic [KIND_W-1:0] kind);
    int          sel;
    int          a;
    logic [31:0] chunk_pages;
    logic [63:0] span;
    chunk_pages = 32'd1;
    sel = $urandom_range(9);
    if (sel <= 2) begin
      base = $urandom;
    end else if (sel <= 7) begin
      a           = $urandom_range(PAGE_BITS, ADDR_W - 1);
      base        = ($urandom | 32'd1) << a;
      chunk_pages = 32'd1 << (a - PAGE_BITS);
    end else if (sel == 8) begin
      base        = '0;
      chunk_pages = 32'd1 << PAGE_ADDR_W;
    end else begin
      base = $urandom & 32'hFFFF_F000;
    end

    sel = $urandom_range(9);
    if (sel == 0) begin
      bytes = $urandom;
    end else if (sel == 1) begin
      bytes = '0;
    end else begin
      if (sel <= 4) span = 64'($urandom_range(1, 12));
      else span = 64'(chunk_pages) * $urandom_range(1, 3)
                  + $urandom_range(0, chunk_pages - 1);
      if (span > (64'd1 << PAGE_ADDR_W)) span = 64'd1 << PAGE_ADDR_W;
      span = (span << PAGE_BITS) - $urandom_range(0, 4095);
      bytes = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    end
    kind = KIND_W'($urandom_range(7));
  endtask

  // Block idle once every owed word is in; sample at the falling edge so
  // the monitor's pop at the rising edge is settled.
  task automatic wait_drained();
    while (pending_entries.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    range_count = value;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] bytes;
    logic [KIND_W-1:0] kind;

    rst                  = 1'b1;
    req_bus.valid        = 1'b0;
    req_bus.base_address = '0;
    req_bus.range_bytes  = '0;
    req_bus.memory_kind  = '0;
    ent_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    range_count          = CFG_RESET;
    mismatches           = 0;
    calm                 = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part runs at the reset count
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_range(DIR_TABLE[r].base, DIR_TABLE[r].bytes, DIR_TABLE[r].kind,
                 DIR_TABLE[r].typed, DIR_TABLE[r].want);
    end
    req_bus.valid <= 1'b0;

    // random phases, one register setting each
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_count(PHASE_COUNTS[p]);
      calm = (p == CALM_PHASE);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pick_range(base, bytes, kind);
        send_range(base, bytes, kind, 1'b0, NO_WANT);
      end
      req_bus.valid <= 1'b0;
    end
    calm = 1'b0;

    // drain, then keep the clock running to catch stray words
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
